FILE: sv/ucb_pkg.sv
// Shared types and constants of the UCB child selector.
`default_nettype none
package ucb_pkg;

   localparam int GAIN_W    = 24;
   localparam int VISITS_W  = 24;
   localparam int WINS_W    = 32;
   localparam int PRIOR_W   = 17;
   localparam int SCORE_W   = 40;
   localparam int IDX_W     = 8;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_GAIN = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE = 1'b1;

   localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd65536;

   localparam int DIV_NW = 40;
   localparam int DIV_DW = 25;
   localparam int SQ_RW  = 56;
   localparam int SQ_QW  = 28;
   localparam int E_W    = 37;
   localparam int G_W    = 25;
   localparam int L_W    = 21;

   localparam logic [SCORE_W-1:0] HALF_Q16 = 40'd32768;
   localparam logic [SCORE_W-1:0] ONE_Q16  = 40'd65536;
   localparam logic [31:0]        LN2_Q32  = 32'd2977044471;

   localparam logic [2:0] MUL_CP = 3'd0;
   localparam logic [2:0] MUL_GS = 3'd1;
   localparam logic [2:0] MUL_MM = 3'd2;
   localparam logic [2:0] MUL_LN = 3'd3;
   localparam logic [2:0] MUL_CR = 3'd4;

   localparam logic [1:0] DIV_Q = 2'd0;
   localparam logic [1:0] DIV_E = 2'd1;
   localparam logic [1:0] DIV_X = 2'd2;

   localparam logic SQ_S = 1'b0;
   localparam logic SQ_R = 1'b1;

   typedef struct packed {
      logic       load;
      logic       q_half;
      logic       div_start;
      logic [1:0] div_sel;
      logic       q_cap;
      logic [2:0] mul_sel;
      logic       g_cap;
      logic       sq_start;
      logic       sq_sel;
      logic       e_div_cap;
      logic       ln_init;
      logic       norm_shift;
      logic       l2_init;
      logic       sq_step;
      logic       l_cap;
      logic       l_zero;
      logic       e_mul_cap;
      logic       sum;
      logic       finish;
   } ucb_cmd_type;

   typedef struct packed {
      logic visits_zero;
      logic parent_le1;
      logic puct;
      logic unv_taken;
      logic div_done;
      logic sq_done;
      logic m_top;
      logic bit_zero;
      logic rsp_busy;
   } ucb_stat_type;

endpackage
`default_nettype wire

FILE: sv/ucb_if.sv
// Request and response channel interfaces of the UCB child selector.
`default_nettype none
interface ucb_req_if;
   logic                         valid;
   logic                         ready;
   logic [ucb_pkg::VISITS_W-1:0] child_visits;
   logic [ucb_pkg::WINS_W-1:0]   child_wins;
   logic [ucb_pkg::PRIOR_W-1:0]  child_prior;
   logic [ucb_pkg::VISITS_W-1:0] parent_visits;
   logic                         mover_is_max;
   logic                         last_child;
   modport source (output valid, child_visits, child_wins, child_prior, parent_visits,
                   mover_is_max, last_child, input ready);
   modport sink (input valid, child_visits, child_wins, child_prior, parent_visits,
                 mover_is_max, last_child, output ready);
endinterface

interface ucb_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [ucb_pkg::IDX_W-1:0]   child_index;
   logic [ucb_pkg::SCORE_W-1:0] score;
   logic                        score_valid;
   logic [ucb_pkg::IDX_W-1:0]   best_index;
   logic                        group_done;
   modport source (output valid, child_index, score, score_valid, best_index, group_done,
                   input ready);
   modport sink (input valid, child_index, score, score_valid, best_index, group_done,
                 output ready);
endinterface
`default_nettype wire

FILE: sv/ucb_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module ucb_div import ucb_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIV_NW-1:0] dividend,
   input  logic [DIV_DW-1:0] divisor,
   output logic [DIV_NW-1:0] quotient,
   output logic              done
);
   localparam int CW = $clog2(DIV_NW);

   logic [DIV_NW-1:0] quo_ff, quo_in;
   logic [DIV_DW-1:0] rem_ff, rem_in, dvs_ff, dvs_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              busy_ff, busy_in, done_ff, done_in;
   logic [DIV_DW:0]   shifted, diff;

   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_NW-1]};
      diff    = shifted - {1'b0, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, dvs_ff}) begin
            rem_in = diff[DIV_DW-1:0];
            quo_in = {quo_ff[DIV_NW-2:0], 1'b1};
         end else begin
            rem_in = shifted[DIV_DW-1:0];
            quo_in = {quo_ff[DIV_NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(DIV_NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;
endmodule
`default_nettype wire

FILE: sv/ucb_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
`default_nettype none
module ucb_sqrt import ucb_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [SQ_RW-1:0] radicand,
   output logic [SQ_QW-1:0] root,
   output logic             done
);
   localparam int CW = $clog2(SQ_QW);

   logic [SQ_RW-1:0] rad_ff, rad_in;
   logic [SQ_QW+1:0] rem_ff, rem_in;
   logic [SQ_QW-1:0] root_ff, root_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [SQ_QW+3:0] cur, trial, diff;

   always_comb begin
      cur     = {rem_ff, rad_ff[SQ_RW-1:SQ_RW-2]};
      trial   = {2'b00, root_ff, 2'b01};
      diff    = cur - trial;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[SQ_RW-3:0], 2'b00};
         if (cur >= trial) begin
            rem_in  = diff[SQ_QW+1:0];
            root_in = {root_ff[SQ_QW-2:0], 1'b1};
         end else begin
            rem_in  = cur[SQ_QW+1:0];
            root_in = {root_ff[SQ_QW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(SQ_QW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

   assign root = root_ff;
   assign done = done_ff;
endmodule
`default_nettype wire

FILE: sv/ucb_dp.sv
// Datapath: operand registers, shared multiplier, divider, square root and group state.
`default_nettype none
module ucb_dp import ucb_pkg::*; #(
   parameter int MAX_CHILDREN = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ucb_cmd_type          cmd,
   output ucb_stat_type         stat,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [GAIN_W-1:0]    csr_wdata,
   input  logic [VISITS_W-1:0]  child_visits,
   input  logic [WINS_W-1:0]    child_wins,
   input  logic [PRIOR_W-1:0]   child_prior,
   input  logic [VISITS_W-1:0]  parent_visits,
   input  logic                 mover_is_max,
   input  logic                 last_child,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic [IDX_W-1:0]     rsp_child_index,
   output logic [SCORE_W-1:0]   rsp_score,
   output logic                 rsp_score_valid,
   output logic [IDX_W-1:0]     rsp_best_index,
   output logic                 rsp_group_done
);
   localparam int LIMIT = (MAX_CHILDREN < 256) ? MAX_CHILDREN : 256;
   localparam logic [IDX_W-1:0] CNT_LAST = IDX_W'(LIMIT - 1);

   logic [GAIN_W-1:0]   gain_ff;
   logic                mode_ff;
   logic [VISITS_W-1:0] vis_ff, par_ff;
   logic [WINS_W-1:0]   wins_ff;
   logic [PRIOR_W-1:0]  prior_ff;
   logic                max_ff, last_ff;
   logic [SCORE_W-1:0]  q_ff, score_ff;
   logic                sv_ff;
   logic [E_W-1:0]      e_ff;
   logic [G_W-1:0]      g_ff;
   logic [31:0]         m_ff;
   logic [4:0]          k_ff;
   logic [3:0]          bit_ff;
   logic [L_W-1:0]      l2_ff, l_ff;
   logic [63:0]         prod_ff;
   logic [31:0]         mul_a, mul_b;
   logic [DIV_NW-1:0]   div_n, quo;
   logic [DIV_DW-1:0]   div_d;
   logic                div_done, sq_done;
   logic [SQ_RW-1:0]    sq_rad;
   logic [SQ_QW-1:0]    root;
   logic [SCORE_W-1:0]  q_adj;
   logic [32:0]         m2;
   logic [SCORE_W:0]    sum_w;

   logic [SCORE_W-1:0]  best_score_ff, best_score_in;
   logic [IDX_W-1:0]    best_child_ff, best_child_in, cnt_ff, cnt_in;
   logic                have_ff, have_in, unv_ff, unv_in;
   logic                rsp_valid_ff;
   logic [IDX_W-1:0]    o_idx_ff, o_best_ff, o_best_in;
   logic [SCORE_W-1:0]  o_score_ff;
   logic                o_sv_ff, o_done_ff;

   ucb_div u_div (
      .clock, .reset, .start(cmd.div_start), .dividend(div_n), .divisor(div_d),
      .quotient(quo), .done(div_done)
   );

   ucb_sqrt u_sqrt (
      .clock, .reset, .start(cmd.sq_start), .radicand(sq_rad), .root(root), .done(sq_done)
   );

   always_comb begin
      case (cmd.mul_sel)
         MUL_CP: begin
            mul_a = 32'(gain_ff);
            mul_b = 32'(prior_ff);
         end
         MUL_GS: begin
            mul_a = 32'(g_ff);
            mul_b = 32'(root);
         end
         MUL_MM: begin
            mul_a = m_ff;
            mul_b = m_ff;
         end
         MUL_LN: begin
            mul_a = 32'(l2_ff);
            mul_b = LN2_Q32;
         end
         MUL_CR: begin
            mul_a = 32'(gain_ff);
            mul_b = 32'(root[18:0]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      case (cmd.div_sel)
         DIV_Q: begin
            div_n = {wins_ff, 8'd0};
            div_d = DIV_DW'(vis_ff);
         end
         DIV_E: begin
            div_n = DIV_NW'(prod_ff[52:16]);
            div_d = DIV_DW'(vis_ff) + 1'b1;
         end
         DIV_X: begin
            div_n = DIV_NW'(l_ff);
            div_d = DIV_DW'(vis_ff);
         end
         default: begin
            div_n = '0;
            div_d = '0;
         end
      endcase
   end

   assign sq_rad = (cmd.sq_sel == SQ_S) ? {par_ff, 32'd0} : {19'd0, quo[L_W-1:0], 16'd0};

   always_comb begin
      if (max_ff) begin
         q_adj = quo;
      end else if (quo > ONE_Q16) begin
         q_adj = '0;
      end else begin
         q_adj = ONE_Q16 - quo;
      end
   end

   assign m2    = prod_ff[63:31];
   assign sum_w = {1'b0, q_ff} + (SCORE_W + 1)'(e_ff);

   always_comb begin
      best_score_in = best_score_ff;
      best_child_in = best_child_ff;
      have_in       = have_ff;
      unv_in        = unv_ff;
      if (!mode_ff && !unv_ff && vis_ff == '0) begin
         unv_in        = 1'b1;
         best_child_in = cnt_ff;
         have_in       = 1'b1;
      end
      if (sv_ff && !unv_in && (!have_in || score_ff > best_score_in)) begin
         best_score_in = score_ff;
         best_child_in = cnt_ff;
         have_in       = 1'b1;
      end
      o_best_in = (last_ff && have_in) ? best_child_in : '0;
      if (last_ff) begin
         best_score_in = '0;
         best_child_in = '0;
         have_in       = 1'b0;
         unv_in        = 1'b0;
         cnt_in        = '0;
      end else if (cnt_ff == CNT_LAST) begin
         cnt_in = '0;
      end else begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff       <= GAIN_RESET;
         mode_ff       <= 1'b0;
         best_score_ff <= '0;
         best_child_ff <= '0;
         cnt_ff        <= '0;
         have_ff       <= 1'b0;
         unv_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_GAIN: gain_ff <= csr_wdata;
               CSR_MODE: mode_ff <= csr_wdata[0];
               default:  gain_ff <= gain_ff;
            endcase
         end
         if (cmd.finish) begin
            best_score_ff <= best_score_in;
            best_child_ff <= best_child_in;
            cnt_ff        <= cnt_in;
            have_ff       <= have_in;
            unv_ff        <= unv_in;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= 64'(mul_a) * 64'(mul_b);
      if (cmd.load) begin
         vis_ff   <= child_visits;
         wins_ff  <= child_wins;
         prior_ff <= child_prior;
         par_ff   <= parent_visits;
         max_ff   <= mover_is_max;
         last_ff  <= last_child;
         q_ff     <= '0;
         e_ff     <= '0;
         score_ff <= '0;
         sv_ff    <= 1'b0;
      end
      if (cmd.q_half)    q_ff <= HALF_Q16;
      if (cmd.q_cap)     q_ff <= q_adj;
      if (cmd.g_cap)     g_ff <= prod_ff[40:16];
      if (cmd.e_div_cap) e_ff <= quo[E_W-1:0];
      if (cmd.e_mul_cap) e_ff <= E_W'(prod_ff[42:16]);
      if (cmd.ln_init) begin
         m_ff   <= 32'(par_ff);
         k_ff   <= 5'd31;
         bit_ff <= 4'd15;
      end
      if (cmd.norm_shift) begin
         m_ff <= {m_ff[30:0], 1'b0};
         k_ff <= k_ff - 1'b1;
      end
      if (cmd.l2_init) l2_ff <= {k_ff, 16'd0};
      if (cmd.sq_step) begin
         if (m2[32]) begin
            m_ff  <= m2[32:1];
            l2_ff <= l2_ff | (L_W'(1) << bit_ff);
         end else begin
            m_ff  <= m2[31:0];
         end
         bit_ff <= bit_ff - 1'b1;
      end
      if (cmd.l_cap)  l_ff <= prod_ff[52:32];
      if (cmd.l_zero) l_ff <= '0;
      if (cmd.sum) begin
         score_ff <= sum_w[SCORE_W] ? '1 : sum_w[SCORE_W-1:0];
         sv_ff    <= 1'b1;
      end
      if (cmd.finish) begin
         o_idx_ff   <= cnt_ff;
         o_score_ff <= score_ff;
         o_sv_ff    <= sv_ff;
         o_best_ff  <= o_best_in;
         o_done_ff  <= last_ff;
      end
   end

   assign stat.visits_zero = (vis_ff == '0);
   assign stat.parent_le1  = (par_ff <= VISITS_W'(1));
   assign stat.puct        = mode_ff;
   assign stat.unv_taken   = unv_ff;
   assign stat.div_done    = div_done;
   assign stat.sq_done     = sq_done;
   assign stat.m_top       = m_ff[31];
   assign stat.bit_zero    = (bit_ff == '0);
   assign stat.rsp_busy    = rsp_valid_ff && !rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_child_index = o_idx_ff;
   assign rsp_score       = o_score_ff;
   assign rsp_score_valid = o_sv_ff;
   assign rsp_best_index  = o_best_ff;
   assign rsp_group_done  = o_done_ff;
endmodule
`default_nettype wire

FILE: sv/ucb_ctrl.sv
// Controller state machine that sequences the scoring steps of one child.
`default_nettype none
module ucb_ctrl import ucb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  ucb_stat_type stat,
   output ucb_cmd_type  cmd
);
   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_Q0    = 5'd1;
   localparam logic [4:0] S_QW    = 5'd2;
   localparam logic [4:0] S_BR    = 5'd3;
   localparam logic [4:0] S_PG    = 5'd4;
   localparam logic [4:0] S_PG2   = 5'd5;
   localparam logic [4:0] S_PS    = 5'd6;
   localparam logic [4:0] S_PM    = 5'd7;
   localparam logic [4:0] S_PM2   = 5'd8;
   localparam logic [4:0] S_PD    = 5'd9;
   localparam logic [4:0] S_UN    = 5'd10;
   localparam logic [4:0] S_UNORM = 5'd11;
   localparam logic [4:0] S_ULM   = 5'd12;
   localparam logic [4:0] S_ULS   = 5'd13;
   localparam logic [4:0] S_ULN   = 5'd14;
   localparam logic [4:0] S_ULN2  = 5'd15;
   localparam logic [4:0] S_UD    = 5'd16;
   localparam logic [4:0] S_UDW   = 5'd17;
   localparam logic [4:0] S_USQ   = 5'd18;
   localparam logic [4:0] S_USW   = 5'd19;
   localparam logic [4:0] S_UM    = 5'd20;
   localparam logic [4:0] S_UM2   = 5'd21;
   localparam logic [4:0] S_SUM   = 5'd22;
   localparam logic [4:0] S_OUT   = 5'd23;

   logic [4:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_Q0;
            end
         end
         S_Q0: begin
            if (!stat.puct && (stat.unv_taken || stat.visits_zero)) begin
               state_in = S_OUT;
            end else if (stat.visits_zero) begin
               cmd.q_half = 1'b1;
               state_in   = S_BR;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_Q;
               state_in      = S_QW;
            end
         end
         S_QW: begin
            if (stat.div_done) begin
               cmd.q_cap = 1'b1;
               state_in  = S_BR;
            end
         end
         S_BR: begin
            state_in = stat.puct ? S_PG : S_UN;
         end
         S_PG: begin
            cmd.mul_sel = MUL_CP;
            state_in    = S_PG2;
         end
         S_PG2: begin
            cmd.g_cap    = 1'b1;
            cmd.sq_start = 1'b1;
            cmd.sq_sel   = SQ_S;
            state_in     = S_PS;
         end
         S_PS: begin
            if (stat.sq_done) state_in = S_PM;
         end
         S_PM: begin
            cmd.mul_sel = MUL_GS;
            state_in    = S_PM2;
         end
         S_PM2: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_E;
            state_in      = S_PD;
         end
         S_PD: begin
            if (stat.div_done) begin
               cmd.e_div_cap = 1'b1;
               state_in      = S_SUM;
            end
         end
         S_UN: begin
            if (stat.parent_le1) begin
               cmd.l_zero = 1'b1;
               state_in   = S_UD;
            end else begin
               cmd.ln_init = 1'b1;
               state_in    = S_UNORM;
            end
         end
         S_UNORM: begin
            if (stat.m_top) begin
               cmd.l2_init = 1'b1;
               state_in    = S_ULM;
            end else begin
               cmd.norm_shift = 1'b1;
            end
         end
         S_ULM: begin
            cmd.mul_sel = MUL_MM;
            state_in    = S_ULS;
         end
         S_ULS: begin
            cmd.sq_step = 1'b1;
            state_in    = stat.bit_zero ? S_ULN : S_ULM;
         end
         S_ULN: begin
            cmd.mul_sel = MUL_LN;
            state_in    = S_ULN2;
         end
         S_ULN2: begin
            cmd.l_cap = 1'b1;
            state_in  = S_UD;
         end
         S_UD: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_X;
            state_in      = S_UDW;
         end
         S_UDW: begin
            if (stat.div_done) state_in = S_USQ;
         end
         S_USQ: begin
            cmd.sq_start = 1'b1;
            cmd.sq_sel   = SQ_R;
            state_in     = S_USW;
         end
         S_USW: begin
            if (stat.sq_done) state_in = S_UM;
         end
         S_UM: begin
            cmd.mul_sel = MUL_CR;
            state_in    = S_UM2;
         end
         S_UM2: begin
            cmd.e_mul_cap = 1'b1;
            state_in      = S_SUM;
         end
         S_SUM: begin
            cmd.sum  = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!stat.rsp_busy) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

FILE: sv/ucb_child_selector.sv
// Top level of the UCB1/PUCT child selector.
// One child beat at a time. The work per child is set by the bit-serial divider
// and square-root unit, in PUCT mode and in UCB1 mode, and in UCB1 mode also by
// the 16 squaring steps of the log. An unvisited or skipped UCB1 child goes
// straight to its result without scoring. A new beat is taken while a result waits.
// Synchronous reset clears the group state and loads the register defaults.
`default_nettype none
module ucb_child_selector import ucb_pkg::*; #(
   parameter int MAX_CHILDREN = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   ucb_req_if.sink              req_if,
   ucb_rsp_if.source            rsp_if,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [GAIN_W-1:0]    csr_wdata
);
   ucb_cmd_type  cmd;
   ucb_stat_type stat;

   ucb_ctrl u_ctrl (
      .clock, .reset, .req_valid(req_if.valid), .req_ready(req_if.ready), .stat, .cmd
   );

   ucb_dp #(.MAX_CHILDREN(MAX_CHILDREN)) u_dp (
      .clock, .reset, .cmd, .stat, .csr_we, .csr_index, .csr_wdata,
      .child_visits(req_if.child_visits), .child_wins(req_if.child_wins),
      .child_prior(req_if.child_prior), .parent_visits(req_if.parent_visits),
      .mover_is_max(req_if.mover_is_max), .last_child(req_if.last_child),
      .rsp_ready(rsp_if.ready), .rsp_valid(rsp_if.valid),
      .rsp_child_index(rsp_if.child_index), .rsp_score(rsp_if.score),
      .rsp_score_valid(rsp_if.score_valid), .rsp_best_index(rsp_if.best_index),
      .rsp_group_done(rsp_if.group_done)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> !req_if.ready)
      else $error("request accepted while a child is in work");

   a_best_only_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.group_done |-> rsp_if.best_index == '0)
      else $error("best index shown before last child");

   a_score_zero_unscored: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.score_valid |-> rsp_if.score == '0)
      else $error("score shown for unscored child");

   a_finish_frees_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_if.valid)
      else $error("finished child lost");
endmodule
`default_nettype wire

FILE: tb/tb_ucb_child_selector.sv
// Self-checking testbench of the UCB child selector: scores children and checks each result beat.
`default_nettype none
module tb_ucb_child_selector;
   import ucb_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint SCORE_TOP = 64'hFF_FFFF_FFFF;

   typedef struct {
      logic [VISITS_W-1:0] visits;
      logic [WINS_W-1:0]   wins;
      logic [PRIOR_W-1:0]  prior;
      logic [VISITS_W-1:0] parent;
      logic                is_max;
      logic                last;
   } child_type;

   typedef struct {
      logic [IDX_W-1:0]   idx;
      logic [SCORE_W-1:0] score;
      logic               score_ok;
      logic [IDX_W-1:0]   best;
      logic               done;
   } pick_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [GAIN_W-1:0] csr_wdata = '0;

   ucb_req_if req_if ();
   ucb_rsp_if rsp_if ();

   ucb_child_selector dut (
      .clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   // predictor state
   logic [GAIN_W-1:0] gain_m = GAIN_RESET;
   logic              puct_m = 1'b0;
   logic [63:0]       top_score;
   logic [IDX_W-1:0]  top_child, child_no;
   logic              have_top, unvisited;

   pick_type picks_due[$];
   bit       broken = 0;
   int       rsp_hold = 0;

   function automatic longint unsigned root64(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic longint unsigned ln_fixed(longint unsigned p);
      int k;
      longint unsigned m, l2;
      logic [127:0] wide;
      k = 0;
      if (p <= 1) return 0;
      while (k < 63 && (p >> (k + 1)) != 0) k++;
      m = p << (31 - k);
      l2 = longint'(k) << 16;
      for (int i = 15; i >= 0; i--) begin
         m = (m * m) >> 31;
         if (m >= (64'd1 << 32)) begin
            m >>= 1;
            l2 |= 64'd1 << i;
         end
      end
      wide = 128'(l2) * 128'(LN2_Q32);
      return 64'(wide >> 32);
   endfunction

   function automatic void clear_group();
      top_score = 0;
      top_child = 0;
      child_no = 0;
      have_top = 0;
      unvisited = 0;
   endfunction

   function automatic pick_type score_child(child_type c);
      pick_type p;
      longint unsigned q, s, g, e, x, r, sc;
      logic ok;
      q = 0; sc = 0; ok = 0;
      if (c.visits != 0) begin
         q = (64'(c.wins) << 8) / 64'(c.visits);
         if (!c.is_max) q = (q > 65536) ? 0 : 65536 - q;
      end
      if (puct_m) begin
         s = root64(64'(c.parent) << 32);
         g = (64'(gain_m) * 64'(c.prior)) >> 16;
         e = ((g * s) >> 16) / (64'd1 + 64'(c.visits));
         if (c.visits == 0) q = 32768;
         sc = q + e;
         ok = 1;
      end else if (!unvisited) begin
         if (c.visits == 0) begin
            unvisited = 1;
            top_child = child_no;
            have_top = 1;
         end else begin
            x = ln_fixed(64'(c.parent)) / 64'(c.visits);
            r = root64(x << 16);
            e = (64'(gain_m) * r) >> 16;
            sc = q + e;
            ok = 1;
         end
      end
      if (sc > SCORE_TOP) sc = SCORE_TOP;
      if (ok && !unvisited && (!have_top || sc > top_score)) begin
         top_score = sc;
         top_child = child_no;
         have_top = 1;
      end
      p.idx = child_no;
      p.score = sc[SCORE_W-1:0];
      p.score_ok = ok;
      p.best = (c.last && have_top) ? top_child : '0;
      p.done = c.last;
      if (c.last) clear_group();
      else child_no = child_no + 1'b1;
      return p;
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic send_child(child_type c);
      int gap;
      gap = gap_len();
      @(negedge clock);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.child_visits <= c.visits;
      req_if.child_wins <= c.wins;
      req_if.child_prior <= c.prior;
      req_if.parent_visits <= c.parent;
      req_if.mover_is_max <= c.is_max;
      req_if.last_child <= c.last;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      picks_due = {picks_due, score_child(c)};
   endtask

   task automatic drain();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (picks_due.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [GAIN_W-1:0] val);
      drain();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_GAIN) gain_m = val;
      else puct_m = val[0];
   endtask

   function automatic child_type rand_child(logic last);
      child_type c;
      int sel;
      sel = $urandom_range(0, 9);
      c.visits = (sel == 0) ? '0 : (sel < 7) ? VISITS_W'($urandom_range(1, 1000))
                                             : VISITS_W'($urandom);
      c.wins = (sel < 7) ? WINS_W'($urandom_range(0, 256) * c.visits) : $urandom;
      if ($urandom_range(0, 9) == 0) c.wins = $urandom;
      c.prior = ($urandom_range(0, 19) == 0) ? PRIOR_W'($urandom)
                                             : PRIOR_W'($urandom_range(0, 65536));
      c.parent = ($urandom_range(0, 3) == 0) ? VISITS_W'($urandom)
                                             : VISITS_W'($urandom_range(0, 5000));
      c.is_max = 1'($urandom_range(0, 1));
      c.last = last;
      return c;
   endfunction

   task automatic send_node(int n);
      for (int i = 0; i < n; i++) send_child(rand_child(i == n - 1));
   endtask

   task automatic test_directed();
      child_type c;
      write_csr(CSR_MODE, 1'b1);
      c = '{24'd0, 32'd0, 17'd65536, 24'd0, 1'b1, 1'b0};
      send_child(c);
      c = '{24'hFFFFFF, 32'hFFFFFFFF, 17'h1FFFF, 24'hFFFFFF, 1'b0, 1'b0};
      send_child(c);
      c = '{24'd1, 32'hFFFFFFFF, 17'd0, 24'd1, 1'b1, 1'b0};
      send_child(c);
      c = '{24'd4, 32'd512, 17'd30000, 24'd9, 1'b0, 1'b1};
      send_child(c);
      write_csr(CSR_GAIN, 24'hFFFFFF);
      send_child('{24'd0, 32'd0, 17'h1FFFF, 24'hFFFFFF, 1'b1, 1'b1});
      write_csr(CSR_MODE, 1'b0);
      send_child('{24'd1, 32'hFFFFFFFF, 17'd0, 24'hFFFFFF, 1'b1, 1'b0});
      send_child('{24'd5, 32'd256, 17'd0, 24'd0, 1'b1, 1'b0});
      send_child('{24'd5, 32'd256, 17'd0, 24'd1, 1'b0, 1'b1});
      write_csr(CSR_GAIN, 24'd0);
      send_child('{24'd3, 32'd768, 17'd0, 24'd50, 1'b1, 1'b0});
      send_child('{24'd3, 32'd768, 17'd0, 24'd50, 1'b1, 1'b0});
      send_child('{24'd0, 32'd0, 17'd0, 24'd50, 1'b1, 1'b0});
      send_child('{24'd9, 32'd9999, 17'd0, 24'd50, 1'b1, 1'b1});
      write_csr(CSR_GAIN, GAIN_RESET);
      send_child('{24'd2, 32'd100, 17'd0, 24'd20, 1'b1, 1'b0});
      write_csr(CSR_MODE, 1'b1);
      send_child('{24'd2, 32'd900, 17'd100, 24'd20, 1'b1, 1'b0});
      write_csr(CSR_MODE, 1'b0);
      send_child('{24'd0, 32'd0, 17'd0, 24'd20, 1'b0, 1'b0});
      write_csr(CSR_MODE, 1'b1);
      send_child('{24'd1, 32'd999, 17'd65536, 24'd20, 1'b1, 1'b1});
   endtask

   task automatic test_wrap();
      write_csr(CSR_MODE, 1'b0);
      write_csr(CSR_GAIN, 24'd70000);
      send_node(258);
   endtask

   task automatic test_random();
      int n;
      for (int ph = 0; ph < 6; ph++) begin
         write_csr(CSR_MODE, ph[0]);
         write_csr(CSR_GAIN, GAIN_W'((ph == 2) ? 24'hFFFFFF : (ph == 4) ? 24'd0
                                     : GAIN_RESET + $urandom_range(0, 200000)));
         n = 0;
         while (n < 62) begin
            int k;
            k = $urandom_range(1, 6);
            send_node(k);
            n += k;
            if ($urandom_range(0, 9) == 0) drain();
         end
      end
   endtask

   // result monitor
   always @(posedge clock) begin
      pick_type e;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (picks_due.size() == 0) begin
            $error("unexpected result beat");
            broken = 1;
         end else begin
            e = picks_due.pop_front();
            if (rsp_if.child_index !== e.idx) begin
               $error("child_index exp %0d got %0d", e.idx, rsp_if.child_index);
               broken = 1;
            end
            if (rsp_if.score !== e.score) begin
               $error("score exp %0d got %0d", e.score, rsp_if.score);
               broken = 1;
            end
            if (rsp_if.score_valid !== e.score_ok) begin
               $error("score_valid exp %0d got %0d", e.score_ok, rsp_if.score_valid);
               broken = 1;
            end
            if (rsp_if.best_index !== e.best) begin
               $error("best_index exp %0d got %0d", e.best, rsp_if.best_index);
               broken = 1;
            end
            if (rsp_if.group_done !== e.done) begin
               $error("group_done exp %0d got %0d", e.done, rsp_if.group_done);
               broken = 1;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_if.ready <= 1'b0;
      end else if (!rsp_if.ready || rsp_if.valid) begin
         rsp_hold <= gap_len();
         rsp_if.ready <= 1'b1;
      end
   end

   initial begin
      rsp_if.ready = 1'b0;
      req_if.valid = 1'b0;
      req_if.child_visits = '0;
      req_if.child_wins = '0;
      req_if.child_prior = '0;
      req_if.parent_visits = '0;
      req_if.mover_is_max = 1'b0;
      req_if.last_child = 1'b0;
      clear_group();
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_wrap();
      test_random();
      drain();
      if (!broken) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #40ms;
      $display("[FAIL] regression broken");
      $finish;
   end
endmodule
`default_nettype wire
